// ----- rtl/core/wac_pkg.sv -----
// Shared types, constants and arithmetic helpers of the WOLA analysis channelizer.
package wac_pkg;

   localparam int WAC_BINS = 16;
   localparam int WAC_TAPS = 8;
   localparam int WAC_DECIM_RESET = 16;
   localparam int WAC_DRAIN = 2;
   localparam longint unsigned WAC_HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned WAC_Q30_ONE = 64'd1073741824;

   typedef struct packed {
      logic              req_type;
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
      logic [10:0]        coef_index;
      logic signed [15:0] coef_value;
   } req_payload_type;

   typedef struct packed {
      logic [5:0]         bin_index;
      logic signed [31:0] bin_re;
      logic signed [31:0] bin_im;
      logic               last_bin;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FOLD,
      ST_FOLD_WAIT,
      ST_DFT,
      ST_DFT_WAIT,
      ST_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic        sample_wr;
      logic        coef_wr;
      logic        clear_wr;
      logic [10:0] clear_addr;
      logic        fold_issue;
      logic [4:0]  tap;
      logic [5:0]  col;
      logic [5:0]  bin;
      logic        dft_issue;
      logic        dft_first;
      logic        load_out;
      logic        frame_done;
   } ctl_cmd_type;

   typedef struct packed {
      logic frame_due;
      logic out_free;
   } dp_status_type;

   function automatic logic signed [15:0] to_q15(input longint v);
      longint unsigned r;
      r = ($unsigned(v) + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         return 16'sd32767;
      end
      return r[15:0];
   endfunction

   // Twiddle word {re, im} for a first-quadrant angle in Q.30 radians and a quadrant.
   function automatic logic [31:0] twiddle(input longint unsigned a, input int unsigned quad);
      longint unsigned a2;
      longint unsigned ts;
      longint unsigned tc;
      longint ss;
      longint cc;
      logic signed [15:0] cs;
      logic signed [15:0] sn;
      logic signed [15:0] re;
      logic signed [15:0] im;
      a2 = (a * a) >> 30;
      ts = a;
      tc = WAC_Q30_ONE;
      ss = $signed(a);
      cc = $signed(WAC_Q30_ONE);
      ts = ((ts * a2) >> 30) / 6;   tc = ((tc * a2) >> 30) / 2;
      ss = ss - $signed(ts);        cc = cc - $signed(tc);
      ts = ((ts * a2) >> 30) / 20;  tc = ((tc * a2) >> 30) / 12;
      ss = ss + $signed(ts);        cc = cc + $signed(tc);
      ts = ((ts * a2) >> 30) / 42;  tc = ((tc * a2) >> 30) / 30;
      ss = ss - $signed(ts);        cc = cc - $signed(tc);
      ts = ((ts * a2) >> 30) / 72;  tc = ((tc * a2) >> 30) / 56;
      ss = ss + $signed(ts);        cc = cc + $signed(tc);
      ts = ((ts * a2) >> 30) / 110; tc = ((tc * a2) >> 30) / 90;
      ss = ss - $signed(ts);        cc = cc - $signed(tc);
      ts = ((ts * a2) >> 30) / 156; tc = ((tc * a2) >> 30) / 132;
      ss = ss + $signed(ts);        cc = cc + $signed(tc);
      ts = ((ts * a2) >> 30) / 210; tc = ((tc * a2) >> 30) / 182;
      ss = ss - $signed(ts);        cc = cc - $signed(tc);
      ts = ((ts * a2) >> 30) / 272; tc = ((tc * a2) >> 30) / 240;
      ss = ss + $signed(ts);        cc = cc + $signed(tc);
      if (ss < 0) begin
         ss = 0;
      end
      if (cc < 0) begin
         cc = 0;
      end
      cs = to_q15(cc);
      sn = to_q15(ss);
      case (quad)
         0: begin
            re = cs;
            im = -sn;
         end
         1: begin
            re = -sn;
            im = -cs;
         end
         2: begin
            re = -cs;
            im = sn;
         end
         default: begin
            re = sn;
            im = cs;
         end
      endcase
      return {re, im};
   endfunction

   // Rounds a Q.45 sum half up to Q.30 and saturates it to 32 bits.
   function automatic logic [31:0] round_sat(input logic signed [63:0] acc);
      logic signed [63:0] t;
      logic signed [63:0] q;
      logic [31:0] r;
      t = acc + 64'sd16384;
      q = t >>> 15;
      if (q > 64'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (q < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = q[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/wac_controller.sv -----
// Sequencer of the channelizer: clearing pass, sample intake, fold, DFT and result beats.
module wac_controller import wac_pkg::*; #(
   parameter int BINS = WAC_BINS,
   parameter int TAPS = WAC_TAPS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_is_coef,
   output logic          req_stall,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   ctl_state_type state_ff, state_in;
   logic [10:0] clr_ff, clr_in;
   logic [4:0]  tap_ff, tap_in;
   logic [5:0]  col_ff, col_in;
   logic [5:0]  bin_ff, bin_in;
   logic [1:0]  wait_ff, wait_in;
   logic accept;
   logic tap_last, col_last, bin_last, clr_last, wait_last;

   assign tap_last  = tap_ff == 5'(TAPS - 1);
   assign col_last  = col_ff == 6'(BINS - 1);
   assign bin_last  = bin_ff == 6'(BINS - 1);
   assign clr_last  = clr_ff == 11'(BINS * TAPS - 1);
   assign wait_last = wait_ff == 2'(WAC_DRAIN - 1);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && !req_is_coef && status.frame_due) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (tap_last && col_last) begin
               state_in = ST_FOLD_WAIT;
            end
         end
         ST_FOLD_WAIT: begin
            if (wait_last) begin
               state_in = ST_DFT;
            end
         end
         ST_DFT: begin
            if (col_last) begin
               state_in = ST_DFT_WAIT;
            end
         end
         ST_DFT_WAIT: begin
            if (wait_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = bin_last ? ST_IDLE : ST_DFT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      clr_in  = clr_ff;
      tap_in  = tap_ff;
      col_in  = col_ff;
      bin_in  = bin_ff;
      wait_in = 2'd0;
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + 11'd1;
         ST_IDLE: begin
            tap_in = 5'd0;
            col_in = 6'd0;
            bin_in = 6'd0;
         end
         ST_FOLD: begin
            if (tap_last) begin
               tap_in = 5'd0;
               col_in = col_last ? 6'd0 : col_ff + 6'd1;
            end else begin
               tap_in = tap_ff + 5'd1;
            end
         end
         ST_FOLD_WAIT, ST_DFT_WAIT: wait_in = wait_last ? 2'd0 : wait_ff + 2'd1;
         ST_DFT: col_in = col_last ? 6'd0 : col_ff + 6'd1;
         ST_EMIT: begin
            if (status.out_free) begin
               bin_in = bin_ff + 6'd1;
            end
         end
         default: clr_in = clr_ff;
      endcase
   end

   always_comb begin
      req_stall      = state_ff != ST_IDLE;
      cmd.sample_wr  = accept && !req_is_coef;
      cmd.coef_wr    = accept && req_is_coef;
      cmd.clear_wr   = state_ff == ST_CLEAR;
      cmd.clear_addr = clr_ff;
      cmd.fold_issue = state_ff == ST_FOLD;
      cmd.tap        = tap_ff;
      cmd.col        = col_ff;
      cmd.bin        = bin_ff;
      cmd.dft_issue  = state_ff == ST_DFT;
      cmd.dft_first  = col_ff == 6'd0;
      cmd.load_out   = (state_ff == ST_EMIT) && status.out_free;
      cmd.frame_done = (state_ff == ST_EMIT) && status.out_free && bin_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= 11'd0;
         tap_ff   <= 5'd0;
         col_ff   <= 6'd0;
         bin_ff   <= 6'd0;
         wait_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         tap_ff   <= tap_in;
         col_ff   <= col_in;
         bin_ff   <= bin_in;
         wait_ff  <= wait_in;
      end
   end

endmodule

// ----- rtl/core/wac_datapath.sv -----
// Datapath of the channelizer: sample line, coefficients, fold, DFT and result register.
module wac_datapath import wac_pkg::*; #(
   parameter int BINS = WAC_BINS,
   parameter int TAPS = WAC_TAPS
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  logic            csr_valid,
   input  logic [6:0]      csr_data,
   input  ctl_cmd_type     cmd,
   output dp_status_type   status,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   localparam int LINE_LEN = BINS * TAPS;
   localparam int LAW = $clog2(LINE_LEN);
   localparam int BW = $clog2(BINS);
   localparam int FW = 32 + $clog2(TAPS);
   localparam int PW = FW + 16;

   // Constant tables: twiddles and decimation reduced modulo the bin count.
   logic [31:0]   tw_tab [BINS];
   logic [BW-1:0] dmod_tab [128];

   for (genvar p = 0; p < BINS; p++) begin : g_tw
      localparam int unsigned QD = (4 * p) / BINS;
      localparam int unsigned RM = 4 * p - QD * BINS;
      localparam longint unsigned ANG = (longint'(RM) * WAC_HALF_PI_Q30 + BINS / 2) / BINS;
      localparam logic [31:0] TW = twiddle(ANG, QD % 4);
      assign tw_tab[p] = TW;
   end

   for (genvar v = 0; v < 128; v++) begin : g_dmod
      localparam int unsigned DM = v % BINS;
      assign dmod_tab[v] = BW'(DM);
   end

   logic [6:0]    decim_ff;
   logic [6:0]    count_ff, count_in;
   logic [BW-1:0] phase_ff, phase_in;
   logic [LAW-1:0] head_ff, head_in;
   logic [6:0]    dec_eff;

   assign dec_eff = (decim_ff == 7'd0) ? 7'd1 : decim_ff;
   assign status.frame_due = count_ff <= 7'd1;

   always_comb begin
      logic [BW:0] ph;
      ph = {1'b0, phase_ff} + (BW + 1)'(BINS) - {1'b0, dmod_tab[dec_eff]};
      if (ph >= (BW + 1)'(BINS)) begin
         ph = ph - (BW + 1)'(BINS);
      end
      phase_in = cmd.frame_done ? ph[BW-1:0] : phase_ff;
      count_in = count_ff;
      if (cmd.sample_wr) begin
         count_in = (count_ff > 7'd1) ? count_ff - 7'd1 : dec_eff;
      end
      head_in = head_ff;
      if (cmd.sample_wr) begin
         head_in = (head_ff == LAW'(LINE_LEN - 1)) ? '0 : head_ff + LAW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decim_ff <= 7'(WAC_DECIM_RESET);
         count_ff <= 7'd1;
         phase_ff <= '0;
         head_ff  <= '0;
      end else begin
         if (csr_valid) begin
            decim_ff <= csr_data;
         end
         count_ff <= count_in;
         phase_ff <= phase_in;
         head_ff  <= head_in;
      end
   end

   // Sample line as a circular buffer: entry i of the line sits at head minus i.
   logic [31:0]        line_mem [LINE_LEN];
   logic signed [15:0] coef_mem [LINE_LEN];
   logic [31:0]        line_rd_ff;
   logic signed [15:0] coef_rd_ff;
   logic               line_we;
   logic [LAW-1:0]     line_wa, line_ra, coef_ra;
   logic [31:0]        line_wd;
   logic               coef_we;
   logic [LAW:0]       tap_pos, line_diff;

   assign line_we = cmd.clear_wr || cmd.sample_wr;
   assign line_wa = cmd.clear_wr ? cmd.clear_addr[LAW-1:0] : head_in;
   assign line_wd = cmd.clear_wr ? 32'd0 : {req_data.sample_re, req_data.sample_im};
   assign coef_we = cmd.coef_wr && ({1'b0, req_data.coef_index} < 12'(LINE_LEN));

   always_comb begin
      tap_pos   = (LAW + 1)'(cmd.tap) * (LAW + 1)'(BINS) + (LAW + 1)'(cmd.col);
      line_diff = {1'b0, head_ff} - tap_pos;
      if (line_diff[LAW]) begin
         line_diff = line_diff + (LAW + 1)'(LINE_LEN);
      end
      line_ra = line_diff[LAW-1:0];
      coef_ra = tap_pos[LAW-1:0];
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_wa] <= line_wd;
      end
      line_rd_ff <= line_mem[line_ra];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[req_data.coef_index[LAW-1:0]] <= req_data.coef_value;
      end
      coef_rd_ff <= coef_mem[coef_ra];
   end

   // Fold pipeline: read, multiply, accumulate over the taps of one column.
   logic               f_v1_ff, f_v2_ff;
   logic               f_first1_ff, f_first2_ff, f_last1_ff, f_last2_ff;
   logic [BW-1:0]      f_col1_ff, f_col2_ff;
   logic signed [31:0] f_pre_ff, f_pim_ff;
   logic signed [FW-1:0] f_acc_re_ff, f_acc_im_ff, f_sum_re, f_sum_im;
   logic [2*FW-1:0]    fold_mem [BINS];
   logic [2*FW-1:0]    fold_rd_ff;
   logic [BW-1:0]      fold_ra;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v1_ff <= 1'b0;
         f_v2_ff <= 1'b0;
      end else begin
         f_v1_ff <= cmd.fold_issue;
         f_v2_ff <= f_v1_ff;
      end
   end

   always_comb begin
      f_sum_re = f_first2_ff ? FW'(f_pre_ff) : f_acc_re_ff + FW'(f_pre_ff);
      f_sum_im = f_first2_ff ? FW'(f_pim_ff) : f_acc_im_ff + FW'(f_pim_ff);
   end

   always_ff @(posedge clock) begin
      f_first1_ff <= cmd.tap == 5'd0;
      f_last1_ff  <= cmd.tap == 5'(TAPS - 1);
      f_col1_ff   <= cmd.col[BW-1:0];
      f_first2_ff <= f_first1_ff;
      f_last2_ff  <= f_last1_ff;
      f_col2_ff   <= f_col1_ff;
      f_pre_ff    <= $signed(line_rd_ff[31:16]) * coef_rd_ff;
      f_pim_ff    <= $signed(line_rd_ff[15:0]) * coef_rd_ff;
      if (f_v2_ff) begin
         f_acc_re_ff <= f_sum_re;
         f_acc_im_ff <= f_sum_im;
      end
   end

   always_ff @(posedge clock) begin
      if (f_v2_ff && f_last2_ff) begin
         fold_mem[f_col2_ff] <= {f_sum_re, f_sum_im};
      end
      fold_rd_ff <= fold_mem[fold_ra];
   end

   // DFT pipeline: the fold is read reversed and rotated by the running offset.
   logic [BW-1:0] tw_ptr_ff, tw_ptr_in, tw_cur, tw1_ff;
   logic          d_v1_ff, d_v2_ff, d_first1_ff, d_first2_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [63:0]   d_acc_re_ff, d_acc_im_ff;
   logic signed [FW-1:0] u_re, u_im;
   logic signed [15:0]   w_re, w_im;

   always_comb begin
      logic [BW:0] m;
      logic [BW:0] src;
      logic [BW:0] t;
      m = (BW + 1)'(cmd.col[BW-1:0]) + {1'b0, phase_ff};
      if (m >= (BW + 1)'(BINS)) begin
         m = m - (BW + 1)'(BINS);
      end
      src = (m == '0) ? '0 : (BW + 1)'(BINS) - m;
      fold_ra = src[BW-1:0];
      tw_cur = cmd.dft_first ? '0 : tw_ptr_ff;
      t = {1'b0, tw_cur} + (BW + 1)'(cmd.bin[BW-1:0]);
      if (t >= (BW + 1)'(BINS)) begin
         t = t - (BW + 1)'(BINS);
      end
      tw_ptr_in = cmd.dft_issue ? t[BW-1:0] : tw_ptr_ff;
   end

   assign u_re = $signed(fold_rd_ff[2*FW-1:FW]);
   assign u_im = $signed(fold_rd_ff[FW-1:0]);
   assign w_re = $signed(tw_tab[tw1_ff][31:16]);
   assign w_im = $signed(tw_tab[tw1_ff][15:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v1_ff <= 1'b0;
         d_v2_ff <= 1'b0;
      end else begin
         d_v1_ff <= cmd.dft_issue;
         d_v2_ff <= d_v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      tw_ptr_ff   <= tw_ptr_in;
      tw1_ff      <= tw_cur;
      d_first1_ff <= cmd.dft_first;
      d_first2_ff <= d_first1_ff;
      p_rr_ff     <= u_re * w_re;
      p_ii_ff     <= u_im * w_im;
      p_ri_ff     <= u_re * w_im;
      p_ir_ff     <= u_im * w_re;
      if (d_v2_ff) begin
         if (d_first2_ff) begin
            d_acc_re_ff <= 64'(p_rr_ff) - 64'(p_ii_ff);
            d_acc_im_ff <= 64'(p_ri_ff) + 64'(p_ir_ff);
         end else begin
            d_acc_re_ff <= d_acc_re_ff + 64'(p_rr_ff) - 64'(p_ii_ff);
            d_acc_im_ff <= d_acc_im_ff + 64'(p_ri_ff) + 64'(p_ir_ff);
         end
      end
   end

   // Result register: a new bin loads while the previous one is taken.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff.bin_index <= cmd.bin;
         rsp_data_ff.bin_re    <= round_sat(d_acc_re_ff);
         rsp_data_ff.bin_im    <= round_sat(d_acc_im_ff);
         rsp_data_ff.last_bin  <= cmd.bin == 6'(BINS - 1);
      end
   end

endmodule

// ----- rtl/core/wola_analysis_channelizer_core.sv -----
// Top level of the WOLA polyphase analysis channelizer: controller plus datapath.
// A sample that forms no frame, or a coefficient write, leaves the core idle for the next request.
// A frame sample holds off requests through the fold, the DFT and the emission of every bin, plus
// any result stall; the first bin appears after the fold and the first DFT pass.
// Both waits come from the sequential multiply-accumulate walk over the sample line and then the DFT.
// After reset the sample line is cleared while requests are stalled.
module wola_analysis_channelizer_core import wac_pkg::*; #(
   parameter int BINS = WAC_BINS,
   parameter int TAPS = WAC_TAPS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [6:0]      csr_data
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   wac_controller #(
      .BINS(BINS),
      .TAPS(TAPS)
   ) u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_is_coef(req_data.req_type),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   wac_datapath #(
      .BINS(BINS),
      .TAPS(TAPS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_valid(csr_valid && csr_ready),
      .csr_data (csr_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

// ----- tb/wola_analysis_channelizer_core_tb.sv -----
// Self-checking testbench of the WOLA analysis channelizer core with a built-in predictor.
module wola_analysis_channelizer_core_tb;
   import wac_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BINS = WAC_BINS;
   localparam int TAPS = WAC_TAPS;
   localparam int LINE_LEN = BINS * TAPS;
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_COEF = 1'b1;
   localparam int SETTLE_CYCLES = 20;
   localparam int STALL_LIMIT = 6000;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   logic [6:0]      csr_data;

   // Predictor state.
   logic signed [15:0] line_re [LINE_LEN];
   logic signed [15:0] line_im [LINE_LEN];
   logic signed [15:0] coef_store [LINE_LEN];
   logic [6:0]         frame_countdown;
   logic [5:0]         phase_offset;
   logic [6:0]         decimation;
   int                 tw_re [BINS];
   int                 tw_im [BINS];

   rsp_payload_type bin_expect_q [$];
   int              error_count;
   int              send_gap_pct;
   int              stall_pct;
   int              idle_count;

   wola_analysis_channelizer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Twiddles by Taylor series on the first-quadrant angle, rounded to Q1.15 on magnitude.
   function automatic void build_twiddles();
      longint unsigned a, a2, ts, tc, rs, rc;
      longint ss, cc;
      int q, r, cs, sn;
      for (int p = 0; p < BINS; p++) begin
         q = (4 * p) / BINS;
         r = 4 * p - q * BINS;
         a = (longint'(r) * WAC_HALF_PI_Q30 + BINS / 2) / BINS;
         a2 = (a * a) >> 30;
         ts = a;
         tc = WAC_Q30_ONE;
         ss = a;
         cc = WAC_Q30_ONE;
         for (int n = 1; n <= 8; n++) begin
            ts = ((ts * a2) >> 30) / ((2 * n) * (2 * n + 1));
            tc = ((tc * a2) >> 30) / ((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
               ss -= ts;
               cc -= tc;
            end else begin
               ss += ts;
               cc += tc;
            end
         end
         if (ss < 0) ss = 0;
         if (cc < 0) cc = 0;
         rs = (ss + 16384) >> 15;
         rc = (cc + 16384) >> 15;
         sn = (rs > 32767) ? 32767 : int'(rs);
         cs = (rc > 32767) ? 32767 : int'(rc);
         case (q % 4)
            0: begin
               tw_re[p] = cs;
               tw_im[p] = -sn;
            end
            1: begin
               tw_re[p] = -sn;
               tw_im[p] = -cs;
            end
            2: begin
               tw_re[p] = -cs;
               tw_im[p] = sn;
            end
            default: begin
               tw_re[p] = sn;
               tw_im[p] = cs;
            end
         endcase
      end
   endfunction

   function automatic logic [31:0] q45_to_q30_sat(longint acc);
      longint q;
      q = (acc + 16384) >>> 15;
      if (q > 64'sd2147483647) return 32'h7fff_ffff;
      if (q < -64'sd2147483648) return 32'h8000_0000;
      return q[31:0];
   endfunction

   // Applies one accepted request and queues the bins of any frame it forms.
   function automatic void channelize_request(req_payload_type r);
      longint fr [BINS];
      longint fi [BINS];
      longint ur [BINS];
      longint ui [BINS];
      longint ar, ai;
      int dec, m, p;
      rsp_payload_type b;
      if (r.req_type == REQ_COEF) begin
         if (r.coef_index < LINE_LEN) coef_store[r.coef_index] = r.coef_value;
         return;
      end
      for (int i = LINE_LEN - 1; i > 0; i--) begin
         line_re[i] = line_re[i - 1];
         line_im[i] = line_im[i - 1];
      end
      line_re[0] = r.sample_re;
      line_im[0] = r.sample_im;
      dec = (decimation == 0) ? 1 : int'(decimation);
      if (frame_countdown > 1) begin
         frame_countdown--;
         return;
      end
      frame_countdown = 7'(dec);
      for (int j = 0; j < BINS; j++) begin
         fr[j] = 0;
         fi[j] = 0;
         for (int i = 0; i < TAPS; i++) begin
            p = i * BINS + j;
            fr[j] += longint'(line_re[p]) * longint'(coef_store[p]);
            fi[j] += longint'(line_im[p]) * longint'(coef_store[p]);
         end
      end
      // Reversal of entries 1..BINS-1 and the rotation by the phase offset in one step.
      for (int j = 0; j < BINS; j++) begin
         m = (j + phase_offset) % BINS;
         ur[j] = fr[(m == 0) ? 0 : BINS - m];
         ui[j] = fi[(m == 0) ? 0 : BINS - m];
      end
      for (int k = 0; k < BINS; k++) begin
         ar = 0;
         ai = 0;
         for (int j = 0; j < BINS; j++) begin
            p = (j * k) % BINS;
            ar += ur[j] * tw_re[p] - ui[j] * tw_im[p];
            ai += ur[j] * tw_im[p] + ui[j] * tw_re[p];
         end
         b.bin_index = 6'(k);
         b.bin_re = q45_to_q30_sat(ar);
         b.bin_im = q45_to_q30_sat(ai);
         b.last_bin = (k == BINS - 1);
         bin_expect_q.push_back(b);
      end
      phase_offset = 6'((phase_offset + BINS - dec % BINS) % BINS);
   endfunction

   task automatic send_request(req_payload_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_gap_pct && gap < 12) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      channelize_request(r);
   endtask

   task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
      req_payload_type r;
      r = '0;
      r.req_type = REQ_SAMPLE;
      r.sample_re = re;
      r.sample_im = im;
      r.coef_index = 11'($urandom);
      r.coef_value = 16'($urandom);
      send_request(r);
   endtask

   task automatic send_coef(logic [10:0] idx, logic signed [15:0] value);
      req_payload_type r;
      r = '0;
      r.req_type = REQ_COEF;
      r.coef_index = idx;
      r.coef_value = value;
      r.sample_re = 16'($urandom);
      r.sample_im = 16'($urandom);
      send_request(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (bin_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_decimation(logic [6:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      decimation = value;
   endtask

   function automatic logic signed [15:0] pick_q15();
      case ($urandom_range(9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Loads the whole prototype filter, then checks the frame made by the very first sample.
   task automatic test_first_frame();
      send_gap_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < LINE_LEN; i++) send_coef(11'(i), pick_q15());
      send_coef(11'(LINE_LEN), 16'sh1234);
      send_coef(11'h7ff, 16'sh8000);
      send_sample(16'sh7fff, 16'sh8000);
      send_sample(16'sh0001, 16'shffff);
   endtask

   // Full-scale samples against four full-scale taps, one frame per sample, driving saturation.
   task automatic test_saturation();
      write_decimation(7'd1);
      for (int i = 0; i < LINE_LEN; i++) coef_store[i] = coef_store[i];
      for (int i = 0; i < 4; i++) send_coef(11'(i * BINS), 16'sh8000);
      for (int i = 0; i < 6; i++) send_sample(16'sh8000, 16'sh7fff);
      send_sample(16'sh7fff, 16'sh8000);
      send_sample(16'sh0000, 16'sh0000);
   endtask

   // A zero decimation behaves as one.
   task automatic test_decimation_zero();
      write_decimation(7'd0);
      for (int i = 0; i < 3; i++) send_sample(pick_q15(), pick_q15());
   endtask

   task automatic test_random_stream(int gap_pct, int stall_p, logic [6:0] dec, int count);
      write_decimation(dec);
      send_gap_pct = gap_pct;
      stall_pct = stall_p;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 12) send_coef(11'($urandom_range(2047)), pick_q15());
         else send_sample(pick_q15(), pick_q15());
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (bin_expect_q.size() == 0) begin
               $display("%0t: unexpected bin %0d re %0d im %0d", $time,
                        rsp_data.bin_index, rsp_data.bin_re, rsp_data.bin_im);
               error_count++;
            end else begin
               if (rsp_data !== bin_expect_q[0]) begin
                  $display("%0t: bin mismatch expected idx %0d re %0d im %0d last %0b",
                           $time, bin_expect_q[0].bin_index, bin_expect_q[0].bin_re,
                           bin_expect_q[0].bin_im, bin_expect_q[0].last_bin);
                  $display("%0t:               actual idx %0d re %0d im %0d last %0b",
                           $time, rsp_data.bin_index, rsp_data.bin_re, rsp_data.bin_im,
                           rsp_data.last_bin);
                  error_count++;
               end
               void'(bin_expect_q.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      error_count = 0;
      idle_count = 0;
      send_gap_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < LINE_LEN; i++) begin
         line_re[i] = '0;
         line_im[i] = '0;
         coef_store[i] = '0;
      end
      frame_countdown = 7'd1;
      phase_offset = '0;
      decimation = 7'(WAC_DECIM_RESET);
      build_twiddles();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_first_frame();
      test_saturation();
      test_decimation_zero();
      test_random_stream(19, 73, 7'd16, 20);
      test_random_stream(73, 19, 7'd3, 15);
      test_random_stream(0, 0, 7'd64, 12);
      test_random_stream(19, 73, 7'd127, 8);
      test_random_stream(73, 19, 7'd7, 16);
      test_random_stream(0, 0, 7'd1, 12);

      wait_drained();
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
